@@ sv/bsd_pkg.sv @@
// Shared constants, codes and types for the block statistics decimator.
package bsd_pkg;

    // Sample width and default block size
    localparam int SAMPLE_BITS   = 12;
    localparam int MAX_BLOCK_DEF = 128;

    // Stream payload widths (tdata in whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int MODE_W      = 2;
    localparam int LENGTH_W    = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_STAT_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 8'd10;

    // Statistic modes, also used as the result kind
    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic fold;      // sample request accepted this cycle
        logic div_step;  // one divider iteration
        logic load_out;  // move the finished result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic block_done;  // the sample now offered closes the block
        logic avg_mode;    // the closing block needs a division
        logic div_last;    // final divider iteration
        logic out_free;    // output register can take a result
    } status_t;

endpackage

@@ sv/bsd_ctrl.sv @@
// Sequencer for the block statistics decimator: accept, divide, emit.
module bsd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  bsd_pkg::status_t status,
    output bsd_pkg::cmd_t    cmd
);

    bsd_pkg::state_t state_reg;
    bsd_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsd_pkg::ST_IDLE: begin
                if (s_tvalid && status.block_done) begin
                    state_next = status.avg_mode ? bsd_pkg::ST_DIVIDE : bsd_pkg::ST_EMIT;
                end
            end
            bsd_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = bsd_pkg::ST_EMIT;
                end
            end
            bsd_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = bsd_pkg::ST_IDLE;
                end
            end
            default: state_next = bsd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd.fold     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            bsd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.fold = s_tvalid;
            end
            bsd_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            bsd_pkg::ST_EMIT: begin
                cmd.load_out = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/bsd_datapath.sv @@
// Accumulators, restoring divider, configuration and output register.
module bsd_datapath #(
    parameter int MAX_BLOCK = bsd_pkg::MAX_BLOCK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [bsd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  bsd_pkg::cmd_t                     cmd,
    output bsd_pkg::status_t                  status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bsd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [bsd_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int SB     = bsd_pkg::SAMPLE_BITS;
    localparam int POS_W  = $clog2(MAX_BLOCK);
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int LEN_W  = (CNT_W > bsd_pkg::LENGTH_W) ? CNT_W : bsd_pkg::LENGTH_W;
    localparam int SUM_W  = SB + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    // Configuration registers
    logic [bsd_pkg::MODE_W-1:0]   mode_reg;
    logic [bsd_pkg::LENGTH_W-1:0] length_reg;

    // Block accumulators
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SB-1:0]    max_reg, max_next;
    logic [SB-1:0]    min_reg, min_next;

    // Divider and result hold
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SB-1:0]     pick_reg;
    logic [bsd_pkg::MODE_W-1:0] kind_reg;

    // Output register
    logic                       out_valid_reg;
    logic [SB-1:0]              out_value_reg;
    logic [bsd_pkg::MODE_W-1:0] out_kind_reg;

    logic [SB-1:0]    sample;
    logic [SUM_W-1:0] sum_add;
    logic [SB-1:0]    max_new, min_new;
    logic [CNT_W-1:0] held;
    logic [LEN_W-1:0] len_ext, eff_len;
    logic             mode_on, done;
    logic [CNT_W:0]   rem_shift;
    logic             rem_ge;

    // Fold the offered sample into the running statistics
    assign sample  = s_tdata[SB-1:0];
    assign sum_add = sum_reg + SUM_W'(sample);
    assign max_new = (sample > max_reg) ? sample : max_reg;
    assign min_new = (sample < min_reg) ? sample : min_reg;
    assign held    = CNT_W'(pos_reg) + CNT_W'(1);

    // Effective length: zero acts as one, saturate at the block limit
    always_comb begin
        len_ext = LEN_W'(length_reg);
        if (len_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_ext > LEN_W'(MAX_BLOCK)) begin
            eff_len = LEN_W'(MAX_BLOCK);
        end else begin
            eff_len = len_ext;
        end
    end

    assign mode_on = (mode_reg != bsd_pkg::MODE_OFF);
    assign done    = mode_on && (LEN_W'(held) >= eff_len);

    assign status.block_done = done;
    assign status.avg_mode   = (mode_reg == bsd_pkg::MODE_AVG);
    assign status.div_last   = (step_reg == STEP_W'(SUM_W - 1));
    assign status.out_free   = !out_valid_reg || m_tready;

    // Accumulator next values
    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        max_next = max_reg;
        min_next = min_reg;
        if (cmd.fold && mode_on) begin
            if (done) begin
                pos_next = '0;
                sum_next = '0;
                max_next = '0;
                min_next = '1;
            end else begin
                pos_next = held[POS_W-1:0];
                sum_next = sum_add;
                max_next = max_new;
                min_next = min_new;
            end
        end
    end

    // Control state: configuration, accumulators, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= bsd_pkg::MODE_OFF;
            length_reg    <= bsd_pkg::LENGTH_RESET;
            pos_reg       <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bsd_pkg::REG_STAT_MODE:    mode_reg   <= cfg_wdata[bsd_pkg::MODE_W-1:0];
                    bsd_pkg::REG_BLOCK_LENGTH: length_reg <= cfg_wdata[bsd_pkg::LENGTH_W-1:0];
                    default: ;
                endcase
            end
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            max_reg <= max_next;
            min_reg <= min_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // Result payload: divider load and iteration, result capture
    always_ff @(posedge aclk) begin
        if (cmd.fold && done) begin
            kind_reg <= mode_reg;
            pick_reg <= (mode_reg == bsd_pkg::MODE_MAX) ? max_new : min_new;
            quo_reg  <= sum_add;
            rem_reg  <= '0;
            div_reg  <= held;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? CNT_W'(rem_shift - {1'b0, div_reg}) : rem_shift[CNT_W-1:0];
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.load_out) begin
            out_value_reg <= (kind_reg == bsd_pkg::MODE_AVG) ? quo_reg[SB-1:0] : pick_reg;
            out_kind_reg  <= kind_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bsd_pkg::M_TDATA_W'(out_value_reg);
    assign m_tuser  = out_kind_reg;

endmodule

@@ sv/block_stats_decimator_core.sv @@
// Block statistics decimator: average, maximum or minimum per block of samples.
// Throughput: one sample per cycle while a block fills. After the sample that closes a block
// s_tready stays low while the result is emitted (maximum, minimum), or while the restoring
// divider, which retires one quotient bit per cycle, runs and the result is then emitted (average).
// Result: m_tvalid rises once the result is loaded into the output register, later while an earlier
// result waits. Synchronous active-low reset: mode off, length 10, accumulators empty, no result.
module block_stats_decimator_core #(
    parameter int MAX_BLOCK = bsd_pkg::MAX_BLOCK_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsd_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] sample_value
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsd_pkg::M_TDATA_W-1:0]   m_tdata,   // [11:0] stat_value
    output logic [bsd_pkg::M_TUSER_W-1:0]   m_tuser    // [1:0] stat_kind
);

    bsd_pkg::cmd_t    cmd;
    bsd_pkg::status_t status;

    bsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsd_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // A result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while output register busy");

    // A closing sample stalls the input on the next cycle
    a_close_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && status.block_done) |=> !s_tready)
        else $error("input accepted while a block result is pending");

    // Loading the output register raises m_tvalid
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

    // Divider never runs while samples are accepted
    a_div_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_tready)
        else $error("divider active while input ready");
`endif

endmodule
